### hw/rtl/crot_pkg.sv
// ----------------------------------------------------------------------------
// crot_pkg
// shared constants for the circle / rectangle overlap unit
// ----------------------------------------------------------------------------
package crot_pkg;

    localparam int CFG_ADDR_WIDTH = 2;

    typedef logic [CFG_ADDR_WIDTH-1:0] cfg_addr_t;

    // configuration register map
    localparam cfg_addr_t CFG_CENTER_X = 2'd0;
    localparam cfg_addr_t CFG_CENTER_Y = 2'd1;
    localparam cfg_addr_t CFG_RADIUS   = 2'd2;

endpackage

### hw/rtl/crot_if.sv
// ----------------------------------------------------------------------------
// crot channel interfaces
// valid / ready channels for configuration, rectangles and overlap flags
// ----------------------------------------------------------------------------
interface crot_cfg_if
    import crot_pkg::*;
#(
    parameter int COORD_WIDTH = 24
);
    logic                   valid;
    logic                   ready;
    cfg_addr_t              addr;
    logic [COORD_WIDTH-1:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

interface crot_rect_if #(
    parameter int COORD_WIDTH = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] left_x;
    logic signed [COORD_WIDTH-1:0] bottom_y;
    logic signed [COORD_WIDTH-1:0] right_x;
    logic signed [COORD_WIDTH-1:0] top_y;

    modport source (output valid, output left_x, output bottom_y, output right_x,
                    output top_y, input ready);
    modport sink   (input valid, input left_x, input bottom_y, input right_x,
                    input top_y, output ready);
endinterface

interface crot_flag_if;
    logic valid;
    logic ready;
    logic overlaps;

    modport source (output valid, output overlaps, input ready);
    modport sink   (input valid, input overlaps, output ready);
endinterface

### hw/rtl/circle_rect_overlap_test_unit.sv
// ----------------------------------------------------------------------------
// circle_rect_overlap_test_unit
// an accepted rectangle passes through the offset, magnitude, square and compare stages
// throughput: one rectangle per cycle while the result side does not stall; four-stage pipeline
// a stall on the result side freezes every stage; nothing dropped or repeated
// reset clears stage valids and sets center and radius to zero
// ----------------------------------------------------------------------------
module circle_rect_overlap_test_unit
    import crot_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  logic         clk,
    input  logic         rst_n,
    crot_cfg_if.sink     cfg,
    crot_rect_if.sink    rect,
    crot_flag_if.source  result
);

    // coordinate widths:
    //   corner offset, rect minus center          : W+1 signed
    //   doubled center offset and distance bounds : W+2 signed
    //   every magnitude fits in W+1 unsigned bits
    localparam int W   = COORD_WIDTH;
    localparam int DW  = W + 1;
    localparam int DDW = W + 2;
    localparam int MW  = W + 1;

    // ------------------------------------------------------------------------
    // configuration registers, always ready
    // ------------------------------------------------------------------------
    logic signed [W-1:0] center_x_reg;
    logic signed [W-1:0] center_y_reg;
    logic [W-2:0]        radius_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            radius_reg   <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.addr)
                CFG_CENTER_X: center_x_reg <= cfg.data;
                CFG_CENTER_Y: center_y_reg <= cfg.data;
                CFG_RADIUS:   radius_reg   <= cfg.data[W-2:0];
                default:      ;  // unmapped address, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // pipeline control: one global advance, stalls only when the output
    // register is full and not being taken
    // ------------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en;

    assign en         = !v4_reg || result.ready;
    assign rect.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= rect.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // ------------------------------------------------------------------------
    // stage 1: offsets, doubled center offsets, distance bounds, span flags
    // ------------------------------------------------------------------------
    logic signed [DW-1:0]  x0_ext, x1_ext, y0_ext, y1_ext, cx_ext, cy_ext;
    logic signed [DDW-1:0] x0_dd, x1_dd, y0_dd, y1_dd, cx2_dd, cy2_dd, r2_dd;

    logic signed [DW-1:0]  cdx0_reg, cdx1_reg, cdy0_reg, cdy1_reg;
    logic signed [DDW-1:0] odx_reg, ody_reg;
    logic signed [DDW-1:0] bnd_w_reg, bnd_h_reg;   // width + 2r, height + 2r
    logic                  in_x1_reg, in_y1_reg;

    always_comb
    begin
        x0_ext = {rect.left_x[W-1], rect.left_x};
        x1_ext = {rect.right_x[W-1], rect.right_x};
        y0_ext = {rect.bottom_y[W-1], rect.bottom_y};
        y1_ext = {rect.top_y[W-1], rect.top_y};
        cx_ext = {center_x_reg[W-1], center_x_reg};
        cy_ext = {center_y_reg[W-1], center_y_reg};

        x0_dd  = {rect.left_x[W-1], rect.left_x[W-1], rect.left_x};
        x1_dd  = {rect.right_x[W-1], rect.right_x[W-1], rect.right_x};
        y0_dd  = {rect.bottom_y[W-1], rect.bottom_y[W-1], rect.bottom_y};
        y1_dd  = {rect.top_y[W-1], rect.top_y[W-1], rect.top_y};
        cx2_dd = {center_x_reg[W-1], center_x_reg, 1'b0};
        cy2_dd = {center_y_reg[W-1], center_y_reg, 1'b0};
        r2_dd  = {2'b00, radius_reg, 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cdx0_reg  <= x0_ext - cx_ext;
            cdx1_reg  <= x1_ext - cx_ext;
            cdy0_reg  <= y0_ext - cy_ext;
            cdy1_reg  <= y1_ext - cy_ext;
            // doubled so the rectangle center needs no rounding
            odx_reg   <= x0_dd + x1_dd - cx2_dd;
            ody_reg   <= y0_dd + y1_dd - cy2_dd;
            bnd_w_reg <= (x1_dd - x0_dd) + r2_dd;
            bnd_h_reg <= (y1_dd - y0_dd) + r2_dd;
            // strict: a center on an edge is not inside
            in_x1_reg <= (center_x_reg > rect.left_x) && (center_x_reg < rect.right_x);
            in_y1_reg <= (center_y_reg > rect.bottom_y) && (center_y_reg < rect.top_y);
        end
    end

    // ------------------------------------------------------------------------
    // stage 2: magnitudes and bound sign checks
    // ------------------------------------------------------------------------
    logic [DW-1:0]  cdx0_neg, cdx1_neg, cdy0_neg, cdy1_neg;
    logic [DDW-1:0] odx_neg, ody_neg;

    logic [MW-1:0] mag_cx0_reg, mag_cx1_reg, mag_cy0_reg, mag_cy1_reg;
    logic [MW-1:0] mag_ox_reg, mag_oy_reg;
    logic [MW-1:0] bmag_w_reg, bmag_h_reg;
    logic          bpos_w_reg, bpos_h_reg;
    logic          in_x2_reg, in_y2_reg;

    always_comb
    begin
        cdx0_neg = -cdx0_reg;
        cdx1_neg = -cdx1_reg;
        cdy0_neg = -cdy0_reg;
        cdy1_neg = -cdy1_reg;
        odx_neg  = -odx_reg;
        ody_neg  = -ody_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_cx0_reg <= cdx0_reg[DW-1] ? cdx0_neg : cdx0_reg;
            mag_cx1_reg <= cdx1_reg[DW-1] ? cdx1_neg : cdx1_reg;
            mag_cy0_reg <= cdy0_reg[DW-1] ? cdy0_neg : cdy0_reg;
            mag_cy1_reg <= cdy1_reg[DW-1] ? cdy1_neg : cdy1_reg;
            mag_ox_reg  <= odx_reg[DDW-1] ? odx_neg[MW-1:0] : odx_reg[MW-1:0];
            mag_oy_reg  <= ody_reg[DDW-1] ? ody_neg[MW-1:0] : ody_reg[MW-1:0];
            // a bound that is zero or negative kills its test
            bpos_w_reg  <= !bnd_w_reg[DDW-1] && (|bnd_w_reg);
            bpos_h_reg  <= !bnd_h_reg[DDW-1] && (|bnd_h_reg);
            bmag_w_reg  <= bnd_w_reg[MW-1:0];
            bmag_h_reg  <= bnd_h_reg[MW-1:0];
            in_x2_reg   <= in_x1_reg;
            in_y2_reg   <= in_y1_reg;
        end
    end

    // ------------------------------------------------------------------------
    // stages 3 and 4: squares, then sum and compare, inside each tester
    // ------------------------------------------------------------------------
    logic [MW-1:0] radius_mag;
    logic          radius_pos;
    logic [3:0]    corner_hit;
    logic          span_x_hit, span_y_hit;
    logic          in_x3_reg, in_y3_reg, in_x4_reg, in_y4_reg;

    // zero radius: nothing is strictly inside the circle
    assign radius_mag = {2'b00, radius_reg};
    assign radius_pos = |radius_reg;

    crot_dist_test #(.MAG_WIDTH(MW)) u_corner_ll (
        .clk(clk), .en(en), .mag_a(mag_cx0_reg), .mag_b(mag_cy0_reg),
        .bound_mag(radius_mag), .bound_pos(radius_pos), .hit(corner_hit[0])
    );

    crot_dist_test #(.MAG_WIDTH(MW)) u_corner_lr (
        .clk(clk), .en(en), .mag_a(mag_cx1_reg), .mag_b(mag_cy0_reg),
        .bound_mag(radius_mag), .bound_pos(radius_pos), .hit(corner_hit[1])
    );

    crot_dist_test #(.MAG_WIDTH(MW)) u_corner_ur (
        .clk(clk), .en(en), .mag_a(mag_cx1_reg), .mag_b(mag_cy1_reg),
        .bound_mag(radius_mag), .bound_pos(radius_pos), .hit(corner_hit[2])
    );

    crot_dist_test #(.MAG_WIDTH(MW)) u_corner_ul (
        .clk(clk), .en(en), .mag_a(mag_cx0_reg), .mag_b(mag_cy1_reg),
        .bound_mag(radius_mag), .bound_pos(radius_pos), .hit(corner_hit[3])
    );

    // center within x span: compare against half-height plus radius (doubled)
    crot_dist_test #(.MAG_WIDTH(MW)) u_span_x (
        .clk(clk), .en(en), .mag_a(mag_ox_reg), .mag_b(mag_oy_reg),
        .bound_mag(bmag_h_reg), .bound_pos(bpos_h_reg), .hit(span_x_hit)
    );

    // center within y span: compare against half-width plus radius (doubled)
    crot_dist_test #(.MAG_WIDTH(MW)) u_span_y (
        .clk(clk), .en(en), .mag_a(mag_ox_reg), .mag_b(mag_oy_reg),
        .bound_mag(bmag_w_reg), .bound_pos(bpos_w_reg), .hit(span_y_hit)
    );

    // span flags ride alongside the testers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_x3_reg <= in_x2_reg;
            in_y3_reg <= in_y2_reg;
            in_x4_reg <= in_x3_reg;
            in_y4_reg <= in_y3_reg;
        end
    end

    // ------------------------------------------------------------------------
    // result: all stage 4 terms are registers, only an or-reduce here
    // ------------------------------------------------------------------------
    assign result.valid    = v4_reg;
    assign result.overlaps = (|corner_hit)
                           || (in_x4_reg && in_y4_reg)
                           || (in_x4_reg && span_x_hit)
                           || (in_y4_reg && span_y_hit);

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    // a valid item in stage 1 moves on to stage 2 when the pipe advances
    a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && en) |=> v2_reg)
        else $error("stage 1 item lost on advance");

    // a stall holds every stage valid bit
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable({v1_reg, v2_reg, v3_reg, v4_reg}))
        else $error("pipeline valids moved during stall");

    // center strictly inside the rectangle always reports an overlap
    a_inside_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && in_x4_reg && in_y4_reg) |-> result.overlaps)
        else $error("inside center not flagged as overlap");

endmodule

### hw/rtl/crot_dist_test.sv
// ----------------------------------------------------------------------------
// crot_dist_test
// two-stage squared distance compare: a^2 + b^2 < bound^2, bound > 0
// ----------------------------------------------------------------------------
module crot_dist_test #(
    parameter int MAG_WIDTH = 25
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [MAG_WIDTH-1:0] mag_a,
    input  logic [MAG_WIDTH-1:0] mag_b,
    input  logic [MAG_WIDTH-1:0] bound_mag,
    input  logic                 bound_pos,
    output logic                 hit
);

    localparam int SQ_WIDTH  = 2 * MAG_WIDTH;
    localparam int SUM_WIDTH = SQ_WIDTH + 1;

    logic [SQ_WIDTH-1:0] sq_a_reg;
    logic [SQ_WIDTH-1:0] sq_b_reg;
    logic [SQ_WIDTH-1:0] sq_bnd_reg;
    logic                pos_reg;
    logic                hit_reg;
    logic [SUM_WIDTH-1:0] sum_sq;
    logic                hit_next;

    // square stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_a_reg   <= SQ_WIDTH'(mag_a) * SQ_WIDTH'(mag_a);
            sq_b_reg   <= SQ_WIDTH'(mag_b) * SQ_WIDTH'(mag_b);
            sq_bnd_reg <= SQ_WIDTH'(bound_mag) * SQ_WIDTH'(bound_mag);
            pos_reg    <= bound_pos;
        end
    end

    // sum and compare stage
    always_comb
    begin
        sum_sq   = SUM_WIDTH'(sq_a_reg) + SUM_WIDTH'(sq_b_reg);
        hit_next = pos_reg && (sum_sq < SUM_WIDTH'(sq_bnd_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

### test/circle_rect_overlap_test_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_rect_overlap_test_unit_tb
// self-checking bench for the circle / rectangle overlap unit: rectangles go
// in on a valid / ready channel, every flag that comes back is checked in
// order against a flag computed here from the same circle settings, over
// several circle settings and several patterns of sender gaps and result stalls
// ----------------------------------------------------------------------------
module circle_rect_overlap_test_unit_tb
    import crot_pkg::*;
();

    localparam int      CW            = 24;
    localparam int      CLK_PERIOD    = 10;
    localparam int      CYCLE_LIMIT   = 400000;
    localparam int      MAX_REPORTS   = 10;
    localparam int      PHASES        = 8;
    localparam int      RANDOM_ITEMS  = 240;
    localparam int      DRAIN_CYCLES  = 16;
    // index past the register map, writes there must be ignored
    localparam cfg_addr_t CFG_SPARE   = 2'd3;

    localparam longint COORD_MAX = (longint'(1) << (CW - 1)) - 1;
    localparam longint COORD_MIN = -(longint'(1) << (CW - 1));

    // wide enough for doubled offsets squared and summed without overflow
    typedef logic signed [2*CW+7:0] acc_t;

    typedef struct packed {
        logic signed [CW-1:0] left_x;
        logic signed [CW-1:0] bottom_y;
        logic signed [CW-1:0] right_x;
        logic signed [CW-1:0] top_y;
    } rect_t;

    typedef struct packed {
        cfg_addr_t       addr;
        logic [CW-1:0]   data;
    } reg_write_t;

    logic clk = 1'b0;
    logic rst_n;

    crot_cfg_if  #(.COORD_WIDTH(CW)) cfg_bus ();
    crot_rect_if #(.COORD_WIDTH(CW)) rect_bus ();
    crot_flag_if                     flag_bus ();

    circle_rect_overlap_test_unit #(
        .COORD_WIDTH(CW)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .rect   (rect_bus),
        .result (flag_bus)
    );

    // local copy of the circle, follows every accepted register write
    logic signed [CW-1:0] circle_cx;
    logic signed [CW-1:0] circle_cy;
    logic [CW-2:0]        circle_r;

    rect_t      rects_pending[$];
    reg_write_t writes_pending[$];
    bit         flags_expected[$];

    int  send_idle_pct;
    int  recv_stall_pct;
    int  error_count = 0;
    int  cycle_count = 0;
    bit  expected_flag;

    always #(CLK_PERIOD/2) clk = ~clk;

    // true when dx^2 + dy^2 < bound^2 and the bound is positive
    function automatic bit dist_under(acc_t dx, acc_t dy, acc_t bound);
        if (bound <= 0)
            return 1'b0;
        return (dx * dx + dy * dy) < (bound * bound);
    endfunction

    // overlap flag for one rectangle against the current circle; the rectangle
    // center is kept doubled so no rounding is ever needed
    function automatic bit overlap_flag(rect_t rc);
        acc_t x0, y0, x1, y1, cx, cy, r, dx, dy;
        bit   in_x, in_y;
        x0   = acc_t'(rc.left_x);
        y0   = acc_t'(rc.bottom_y);
        x1   = acc_t'(rc.right_x);
        y1   = acc_t'(rc.top_y);
        cx   = acc_t'(circle_cx);
        cy   = acc_t'(circle_cy);
        r    = acc_t'(circle_r);
        in_x = (cx > x0) && (cx < x1);
        in_y = (cy > y0) && (cy < y1);
        dx   = x0 + x1 - 2 * cx;
        dy   = y0 + y1 - 2 * cy;
        return dist_under(x0 - cx, y0 - cy, r)
            || dist_under(x1 - cx, y0 - cy, r)
            || dist_under(x1 - cx, y1 - cy, r)
            || dist_under(x0 - cx, y1 - cy, r)
            || (in_x && in_y)
            || (in_x && dist_under(dx, dy, (y1 - y0) + 2 * r))
            || (in_y && dist_under(dx, dy, (x1 - x0) + 2 * r));
    endfunction

    // ------------------------------------------------------------------
    // rectangle driver: pops the pending queue, inserts random gaps, and
    // records the expected flag the moment a transaction is accepted
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rect_bus.valid    <= 1'b0;
            rect_bus.left_x   <= '0;
            rect_bus.bottom_y <= '0;
            rect_bus.right_x  <= '0;
            rect_bus.top_y    <= '0;
        end
        else
        begin
            if (rect_bus.valid && rect_bus.ready)
                flags_expected.push_back(overlap_flag({rect_bus.left_x, rect_bus.bottom_y,
                                                       rect_bus.right_x, rect_bus.top_y}));
            // a held item may only be replaced once it has gone through
            if (!rect_bus.valid || rect_bus.ready)
            begin
                if (rects_pending.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    rect_bus.valid    <= 1'b1;
                    rect_bus.left_x   <= rects_pending[0].left_x;
                    rect_bus.bottom_y <= rects_pending[0].bottom_y;
                    rect_bus.right_x  <= rects_pending[0].right_x;
                    rect_bus.top_y    <= rects_pending[0].top_y;
                    void'(rects_pending.pop_front());
                end
                else
                begin
                    rect_bus.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // register write driver, the local circle copy follows each transaction
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_bus.valid <= 1'b0;
            cfg_bus.addr  <= CFG_CENTER_X;
            cfg_bus.data  <= '0;
            circle_cx     <= '0;
            circle_cy     <= '0;
            circle_r      <= '0;
        end
        else
        begin
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                case (cfg_bus.addr)
                    CFG_CENTER_X: circle_cx <= cfg_bus.data;
                    CFG_CENTER_Y: circle_cy <= cfg_bus.data;
                    CFG_RADIUS:   circle_r  <= cfg_bus.data[CW-2:0];
                    default:      ;
                endcase
            end
            if (!cfg_bus.valid || cfg_bus.ready)
            begin
                if (writes_pending.size() > 0)
                begin
                    cfg_bus.valid <= 1'b1;
                    cfg_bus.addr  <= writes_pending[0].addr;
                    cfg_bus.data  <= writes_pending[0].data;
                    void'(writes_pending.pop_front());
                end
                else
                begin
                    cfg_bus.valid <= 1'b0;
                end
            end
        end
    end

    // result side back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flag_bus.ready <= 1'b0;
        else
            flag_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // monitor: every accepted flag is matched against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && flag_bus.valid && flag_bus.ready)
        begin
            if (flags_expected.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("overlap flag %0b with no rectangle outstanding",
                             flag_bus.overlaps);
            end
            else
            begin
                expected_flag = flags_expected.pop_front();
                if (flag_bus.overlaps !== expected_flag)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("overlap flag mismatch: expected %0b actual %0b",
                                 expected_flag, flag_bus.overlaps);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic push_rect(longint l, longint b, longint r, longint t);
        rect_t rc;
        rc.left_x   = l[CW-1:0];
        rc.bottom_y = b[CW-1:0];
        rc.right_x  = r[CW-1:0];
        rc.top_y    = t[CW-1:0];
        rects_pending.push_back(rc);
    endtask

    task automatic write_reg(cfg_addr_t addr, longint value);
        reg_write_t wr;
        wr.addr = addr;
        wr.data = value[CW-1:0];
        writes_pending.push_back(wr);
    endtask

    // wait until every rectangle is through and every flag has come back
    task automatic wait_drained();
        while (rects_pending.size() > 0 || rect_bus.valid || flags_expected.size() > 0)
            @(negedge clk);
    endtask

    task automatic wait_written();
        while (writes_pending.size() > 0 || cfg_bus.valid)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // sequencing: reset, then phases of circle settings and gap patterns
    // ------------------------------------------------------------------
    initial
    begin
        int     phase;
        int     n;
        int     roll;
        longint cx, cy, rad, scale, x0, y0, x1, y1;

        rst_n          = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (phase = 0; phase < PHASES; phase++)
        begin
            // gap pattern: none, sender gaps, result stalls, a little of both
            case (phase % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 8;  recv_stall_pct = 8;  end
            endcase

            case (phase)
                0:
                begin
                    // reset circle: zero radius at the origin, so corners never
                    // count and only the strict inside and span tests matter
                    push_rect(0, 0, 0, 0);
                    push_rect(-1, -1, 1, 1);
                    push_rect(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
                    push_rect(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
                    // center on each edge in turn
                    push_rect(0, -1, 1, 1);
                    push_rect(-1, 0, 1, 1);
                    push_rect(-1, -1, 0, 1);
                    push_rect(-1, -1, 1, 0);
                    push_rect(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
                    push_rect(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
                    push_rect(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
                    push_rect(1, 1, 2, 2);
                end
                1:
                begin
                    // small circle at (1.0, -1.0) with radius 2.0
                    write_reg(CFG_CENTER_X, 256);
                    write_reg(CFG_CENTER_Y, -256);
                    write_reg(CFG_RADIUS, 512);
                    wait_written();
                    // corner exactly on the circle, then just inside
                    push_rect(256 + 512, -256, 256 + 1000, -256 + 300);
                    push_rect(256 + 511, -256, 256 + 1000, -256 + 300);
                    // center within the x span, rectangle above the circle
                    push_rect(256 - 100, -256 + 511, 256 + 100, -256 + 600);
                    push_rect(256 - 100, -256 + 512, 256 + 100, -256 + 600);
                    // center within the y span, rectangle right of the circle
                    push_rect(256 + 511, -256 - 100, 256 + 600, -256 + 100);
                    push_rect(256 + 512, -256 - 100, 256 + 600, -256 + 100);
                    // circle fully enclosed, and a zero-width sliver through it
                    push_rect(-2000, -2000, 2000, 2000);
                    push_rect(256, -1000, 256, 1000);
                end
                2:
                begin
                    write_reg(CFG_CENTER_X, COORD_MAX);
                    write_reg(CFG_CENTER_Y, COORD_MIN);
                    write_reg(CFG_RADIUS, COORD_MAX);
                end
                3:
                begin
                    // bit above the radius width must be dropped, giving zero
                    write_reg(CFG_CENTER_X, COORD_MIN);
                    write_reg(CFG_CENTER_Y, COORD_MAX);
                    write_reg(CFG_RADIUS, COORD_MIN);
                    write_reg(CFG_SPARE, longint'($urandom));
                end
                PHASES - 1:
                begin
                    write_reg(CFG_CENTER_X, longint'($urandom));
                    write_reg(CFG_CENTER_Y, longint'($urandom));
                    write_reg(CFG_RADIUS, longint'($urandom));
                end
                default:
                begin
                    write_reg(CFG_CENTER_X, longint'($urandom_range(1 << 21)) - (1 << 20));
                    write_reg(CFG_CENTER_Y, longint'($urandom_range(1 << 21)) - (1 << 20));
                    write_reg(CFG_RADIUS,
                              longint'($urandom_range(1 << $urandom_range(4, 20))));
                end
            endcase
            wait_written();

            cx    = longint'(circle_cx);
            cy    = longint'(circle_cy);
            rad   = longint'(circle_r);
            scale = (rad > 0) ? rad : 256;

            for (n = 0; n < RANDOM_ITEMS; n++)
            begin
                roll = $urandom_range(99);
                if (roll < 15)
                begin
                    // raw noise, every bit free, often inverted
                    push_rect(longint'($urandom), longint'($urandom),
                              longint'($urandom), longint'($urandom));
                end
                else
                begin
                    // rectangle placed around the circle at its own scale;
                    // some come out inverted
                    x0 = cx + longint'($urandom_range(32'(6 * scale))) - 3 * scale;
                    y0 = cy + longint'($urandom_range(32'(6 * scale))) - 3 * scale;
                    x1 = x0 + longint'($urandom_range(32'(5 * scale))) - scale;
                    y1 = y0 + longint'($urandom_range(32'(5 * scale))) - scale;
                    if (roll < 35)
                    begin
                        // snap one edge onto the center or onto the rim
                        case ($urandom_range(5))
                            0:       x0 = cx;
                            1:       x1 = cx;
                            2:       y0 = cy;
                            3:       y1 = cy;
                            4:       x0 = cx + rad;
                            default: y1 = cy - rad;
                        endcase
                    end
                    push_rect(x0, y0, x1, y1);
                end
            end
            wait_drained();
        end

        // let any stray flag show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
